@@ sv/rrfp_pkg.sv @@
// Shared types and constants of the radar report frame parser.
package rrfp_pkg;

  // Frame store geometry
  localparam int MAX_FRAME_BYTES = 64;
  localparam int GATE_COUNT      = 9;
  localparam int FILL_W          = $clog2(MAX_FRAME_BYTES + 1);
  localparam int IDX_W           = $clog2(GATE_COUNT + 2);

  // Framing bytes
  localparam logic [7:0] START_DATA = 8'hF4;
  localparam logic [7:0] START_ACK  = 8'hFD;
  localparam logic [7:0] FOOT_D0    = 8'hF8;
  localparam logic [7:0] FOOT_D1    = 8'hF7;
  localparam logic [7:0] FOOT_D2    = 8'hF6;
  localparam logic [7:0] FOOT_D3    = 8'hF5;
  localparam logic [7:0] FOOT_A0    = 8'h04;
  localparam logic [7:0] FOOT_A1    = 8'h03;
  localparam logic [7:0] FOOT_A2    = 8'h02;
  localparam logic [7:0] FOOT_A3    = 8'h01;
  localparam logic [7:0] HEAD_BYTE  = 8'hAA;
  localparam logic [7:0] TYPE_ENG   = 8'h01;
  localparam logic [7:0] TYPE_BASIC = 8'h02;
  localparam int         LEN_OVERHEAD = 10;

  // Fill index of the byte that brings the frame to eight bytes
  localparam int CHECK_FILL = 7;

  // Frame offsets
  localparam int OFS_LEN_LO     = 4;
  localparam int OFS_LEN_HI     = 5;
  localparam int OFS_TYPE       = 6;
  localparam int OFS_HEAD       = 7;
  localparam int OFS_STATE      = 8;
  localparam int OFS_MDIST      = 9;
  localparam int OFS_MVAL       = 11;
  localparam int OFS_SDIST      = 12;
  localparam int OFS_SVAL       = 14;
  localparam int OFS_DDIST      = 15;
  localparam int OFS_MAX_MOVE   = 17;
  localparam int OFS_MAX_STILL  = 18;
  localparam int OFS_MOVE_GATE  = 19;
  localparam int OFS_STILL_GATE = 28;
  localparam int OFS_LIGHT      = 37;
  localparam int OFS_PIN        = 38;

  typedef enum logic [2:0] {
    KIND_BASIC  = 3'd0,
    KIND_ENG    = 3'd1,
    KIND_LIMITS = 3'd2,
    KIND_GATE   = 3'd3,
    KIND_ERROR  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  target_state;
    logic [15:0] moving_distance;
    logic [7:0]  moving_value;
    logic [15:0] still_distance;
    logic [7:0]  still_value;
    logic [15:0] detect_distance;
    logic [3:0]  gate_index;
    logic [7:0]  light_level;
    logic        out_pin;
    logic        last;
  } result_t;

endpackage

@@ sv/rrfp_if.sv @@
// Channel interfaces of the radar report frame parser.
interface rrfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rrfp_cfg_if;
  logic valid;
  logic ready;
  logic rx_enable;
  modport source (output valid, output rx_enable, input ready);
  modport sink (input valid, input rx_enable, output ready);
endinterface

interface rrfp_result_if;
  logic             valid;
  logic             ready;
  rrfp_pkg::result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ sv/radar_report_frame_parser_top.sv @@
// Top level of the radar report frame parser.
// The parser takes one received byte per clock cycle while rx_enable is set,
// unless held, and hunts for frames opened by F4 (data) or FD (acknowledgement).
// Frame offsets 4 to 38 are held in registers and the footer is matched against
// a three-byte history, so every byte is handled in the cycle it arrives. A
// completed data frame is copied into a snapshot register and drained from a
// result register, one record per cycle unless stalled: one record for a basic
// frame, 11 for an engineering frame, and one error record for a rejected frame.
// While a burst drains, bytes that start a frame or fill its first seven
// positions are still taken; from the eighth on, a byte waits out the burst.
module radar_report_frame_parser_top (
  input  logic                 clk,
  input  logic                 rst,
  rrfp_cfg_if.sink             cfg,
  rrfp_byte_if.sink            rx,
  rrfp_result_if.source        report
);

  localparam int LO = rrfp_pkg::OFS_LEN_LO;
  localparam int HI = rrfp_pkg::OFS_PIN;
  localparam int SLO = rrfp_pkg::OFS_STATE;

  logic                          rx_enable;
  logic                          in_frame;
  logic                          ack_frame;
  logic [rrfp_pkg::FILL_W-1:0]   fill_position;
  logic [7:0]                    frame_bytes [LO:HI];
  logic [7:0]                    store_next [LO:HI];
  logic [7:0]                    hist [3];

  logic                          busy;
  logic                          burst_err;
  logic                          burst_eng;
  logic [rrfp_pkg::IDX_W-1:0]    burst_idx;
  logic [7:0]                    snap [SLO:HI];

  logic                          report_valid;
  rrfp_pkg::result_t             report_data;
  rrfp_pkg::result_t             gen;

  logic                          rx_take;
  logic                          active;
  logic                          store_en;
  logic                          start_hit;
  logic                          in_window;
  logic [16:0]                   len_sum;
  logic                          len_bad;
  logic                          footer_data;
  logic                          footer_ack;
  logic                          ended;
  logic                          full;
  logic                          frame_end;
  logic                          ev_error;
  logic                          ev_report;
  logic                          type_ok;
  logic                          load;
  logic [rrfp_pkg::IDX_W-1:0]    gate;

  // Configuration channel is always ready.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_enable <= 1'b0;
    end else if (cfg.valid) begin
      rx_enable <= cfg.rx_enable;
    end
  end

  // Byte channel: hold bytes that may end a frame while a burst is pending.
  assign in_window = rx_enable && in_frame &&
                     (fill_position >= rrfp_pkg::FILL_W'(rrfp_pkg::CHECK_FILL));
  assign rx.ready  = !busy || !in_window;

  // Store contents including the byte now being written.
  always_comb begin
    for (int i = LO; i <= HI; i++) begin
      store_next[i] = (fill_position == rrfp_pkg::FILL_W'(i)) ? rx.rx_byte
                                                               : frame_bytes[i];
    end
  end

  // Frame checks for the incoming byte.
  always_comb begin
    rx_take   = rx.valid && rx.ready;
    active    = rx_take && rx_enable;
    store_en  = active && in_frame;
    start_hit = (rx.rx_byte == rrfp_pkg::START_DATA) ||
                (rx.rx_byte == rrfp_pkg::START_ACK);
    len_sum   = {1'b0, frame_bytes[rrfp_pkg::OFS_LEN_HI], frame_bytes[rrfp_pkg::OFS_LEN_LO]}
                + 17'(rrfp_pkg::LEN_OVERHEAD);
    len_bad   = (fill_position == rrfp_pkg::FILL_W'(rrfp_pkg::CHECK_FILL)) &&
                (len_sum > 17'(rrfp_pkg::MAX_FRAME_BYTES));
    footer_data = (hist[2] == rrfp_pkg::FOOT_D0) && (hist[1] == rrfp_pkg::FOOT_D1) &&
                  (hist[0] == rrfp_pkg::FOOT_D2) && (rx.rx_byte == rrfp_pkg::FOOT_D3);
    footer_ack  = (hist[2] == rrfp_pkg::FOOT_A0) && (hist[1] == rrfp_pkg::FOOT_A1) &&
                  (hist[0] == rrfp_pkg::FOOT_A2) && (rx.rx_byte == rrfp_pkg::FOOT_A3);
    ended     = (fill_position >= rrfp_pkg::FILL_W'(rrfp_pkg::CHECK_FILL)) &&
                (ack_frame ? footer_ack : footer_data);
    full      = fill_position == rrfp_pkg::FILL_W'(rrfp_pkg::MAX_FRAME_BYTES - 1);
    frame_end = store_en && (len_bad || ended || full);
    ev_error  = store_en && (len_bad || (!ended && full));
    type_ok   = ((store_next[rrfp_pkg::OFS_TYPE] == rrfp_pkg::TYPE_ENG) ||
                 (store_next[rrfp_pkg::OFS_TYPE] == rrfp_pkg::TYPE_BASIC)) &&
                (store_next[rrfp_pkg::OFS_HEAD] == rrfp_pkg::HEAD_BYTE);
    ev_report = store_en && !len_bad && ended && !ack_frame && type_ok;
  end

  // Frame tracking state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      ack_frame     <= 1'b0;
      fill_position <= '0;
    end else if (active) begin
      if (!in_frame) begin
        if (start_hit) begin
          in_frame      <= 1'b1;
          ack_frame     <= (rx.rx_byte == rrfp_pkg::START_ACK);
          fill_position <= rrfp_pkg::FILL_W'(1);
        end
      end else begin
        if (frame_end) begin
          in_frame <= 1'b0;
        end
        if (ev_error) begin
          fill_position <= '0;
        end else begin
          fill_position <= fill_position + rrfp_pkg::FILL_W'(1);
        end
      end
    end
  end

  // Frame store for the offsets that are read; cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = LO; i <= HI; i++) begin
        frame_bytes[i] <= '0;
      end
    end else if (store_en) begin
      for (int i = LO; i <= HI; i++) begin
        frame_bytes[i] <= store_next[i];
      end
    end
  end

  // History of the last three stored bytes for footer matching.
  always_ff @(posedge clk) begin
    if (store_en) begin
      hist[2] <= hist[1];
      hist[1] <= hist[0];
      hist[0] <= rx.rx_byte;
    end
  end

  // Burst sequencer control.
  assign load = busy && (!report_valid || report.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      report_valid <= 1'b0;
    end else begin
      if (!busy && (ev_error || ev_report)) begin
        busy <= 1'b1;
      end else if (load && gen.last) begin
        busy <= 1'b0;
      end
      if (load) begin
        report_valid <= 1'b1;
      end else if (report.ready) begin
        report_valid <= 1'b0;
      end
    end
  end

  // Snapshot and burst position.
  always_ff @(posedge clk) begin
    if (!busy && (ev_error || ev_report)) begin
      burst_err <= ev_error;
      burst_eng <= (store_next[rrfp_pkg::OFS_TYPE] == rrfp_pkg::TYPE_ENG);
      burst_idx <= '0;
      for (int i = SLO; i <= HI; i++) begin
        snap[i] <= store_next[i];
      end
    end else if (load) begin
      burst_idx <= burst_idx + rrfp_pkg::IDX_W'(1);
    end
  end

  // Record generator for the current burst position.
  assign gate = burst_idx - rrfp_pkg::IDX_W'(2);

  always_comb begin
    gen = '0;
    if (burst_err) begin
      gen.kind = rrfp_pkg::KIND_ERROR;
      gen.last = 1'b1;
    end else if (burst_idx == '0) begin
      gen.kind            = burst_eng ? rrfp_pkg::KIND_ENG : rrfp_pkg::KIND_BASIC;
      gen.target_state    = snap[rrfp_pkg::OFS_STATE];
      gen.moving_distance = {snap[rrfp_pkg::OFS_MDIST + 1], snap[rrfp_pkg::OFS_MDIST]};
      gen.moving_value    = snap[rrfp_pkg::OFS_MVAL];
      gen.still_distance  = {snap[rrfp_pkg::OFS_SDIST + 1], snap[rrfp_pkg::OFS_SDIST]};
      gen.still_value     = snap[rrfp_pkg::OFS_SVAL];
      gen.detect_distance = {snap[rrfp_pkg::OFS_DDIST + 1], snap[rrfp_pkg::OFS_DDIST]};
      if (burst_eng) begin
        gen.light_level = snap[rrfp_pkg::OFS_LIGHT];
        gen.out_pin     = (snap[rrfp_pkg::OFS_PIN] != 8'h00);
      end
      gen.last = !burst_eng;
    end else if (burst_idx == rrfp_pkg::IDX_W'(1)) begin
      gen.kind         = rrfp_pkg::KIND_LIMITS;
      gen.moving_value = snap[rrfp_pkg::OFS_MAX_MOVE];
      gen.still_value  = snap[rrfp_pkg::OFS_MAX_STILL];
    end else begin
      gen.kind         = rrfp_pkg::KIND_GATE;
      gen.gate_index   = 4'(gate);
      gen.moving_value = snap[rrfp_pkg::OFS_MOVE_GATE + int'(gate)];
      gen.still_value  = snap[rrfp_pkg::OFS_STILL_GATE + int'(gate)];
      gen.last         = (burst_idx == rrfp_pkg::IDX_W'(rrfp_pkg::GATE_COUNT + 1));
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (load) begin
      report_data <= gen;
    end
  end

  assign report.valid   = report_valid;
  assign report.payload = report_data;

`ifndef ASSERT_OFF
  // The fill never reaches the store size while a frame is open.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    in_frame |-> (fill_position < rrfp_pkg::FILL_W'(rrfp_pkg::MAX_FRAME_BYTES)))
    else $error("fill position beyond frame store");

  // Gate records carry a gate number inside the configured gate count.
  a_gate_range: assert property (@(posedge clk) disable iff (rst)
    (report.valid && (report.payload.kind == rrfp_pkg::KIND_GATE)) |->
      (report.payload.gate_index < 4'(rrfp_pkg::GATE_COUNT)))
    else $error("gate index out of range");

  // An error record always closes its burst.
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (report.valid && (report.payload.kind == rrfp_pkg::KIND_ERROR)) |->
      report.payload.last)
    else $error("error record without last");

  // A frame that may end is never taken while an earlier burst is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (busy && rx.valid && rx.ready) |-> !(ev_error || ev_report))
    else $error("new burst while one is pending");
`endif

endmodule

@@ verif/tb_radar_report_frame_parser_top.sv @@
// Self-checking testbench of the radar report frame parser top level.
`timescale 1ns / 100ps

module tb_radar_report_frame_parser_top;
  import rrfp_pkg::*;

  localparam int CYCLE_LIMIT   = 2000000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_BYTES  = 300;
  localparam int CALM_BYTES    = 240;
  localparam int MIN_REPORTS   = 48;
  localparam int MAX_BODY      = MAX_FRAME_BYTES - 12;
  localparam int MAX_LEN_OK    = MAX_FRAME_BYTES - LEN_OVERHEAD;

  typedef enum logic [1:0] {
    ROW_BYTES,
    ROW_ENABLE
  } row_op_t;

  // One row of the directed table: a byte run or an enable write.
  typedef struct {
    row_op_t                           op;
    int                                count;
    logic [MAX_FRAME_BYTES-1:0][7:0]   bytes;
    logic                              typed;
    int                                n_exp;
    result_t                           exp_rec;
  } stim_row_t;

  logic clk;
  logic rst;

  rrfp_byte_if   rx_ch ();
  rrfp_cfg_if    cfg_ch ();
  rrfp_result_if rep_ch ();

  radar_report_frame_parser_top dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .rx     (rx_ch),
    .report (rep_ch)
  );

  // Shadow copy of the parser state.
  logic        shadow_enable;
  logic        shadow_in_frame;
  logic        shadow_ack;
  int unsigned shadow_fill;
  logic [7:0]  shadow_store [MAX_FRAME_BYTES];

  result_t     expected_reports [$];
  result_t     step_reports [$];
  stim_row_t   rows [$];
  logic [7:0]  scratch [$];

  // Tags that travel with each byte request.
  logic        tag_typed;
  logic        tag_end;
  int          tag_row;

  int          mismatches;
  int          report_count;
  int          predicted_total;
  int          cycle_count;
  int          src_idle_pct;
  int          sink_idle_pct;
  logic        calm;

  // Clock.
  always #6 clk = ~clk;

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH: %s", msg);
  endtask

  function automatic result_t error_record();
    result_t r;
    r      = '0;
    r.kind = KIND_ERROR;
    r.last = 1'b1;
    return r;
  endfunction

  // Decode a completed data frame from the shadow store into its reports.
  task automatic decode_frame(ref result_t recs[$]);
    result_t    r;
    logic       eng;
    logic [7:0] typ;
    typ = shadow_store[OFS_TYPE];
    if ((typ != TYPE_ENG && typ != TYPE_BASIC) || shadow_store[OFS_HEAD] != HEAD_BYTE) return;
    eng               = (typ == TYPE_ENG);
    r                 = '0;
    r.kind            = eng ? KIND_ENG : KIND_BASIC;
    r.target_state    = shadow_store[OFS_STATE];
    r.moving_distance = {shadow_store[OFS_MDIST+1], shadow_store[OFS_MDIST]};
    r.moving_value    = shadow_store[OFS_MVAL];
    r.still_distance  = {shadow_store[OFS_SDIST+1], shadow_store[OFS_SDIST]};
    r.still_value     = shadow_store[OFS_SVAL];
    r.detect_distance = {shadow_store[OFS_DDIST+1], shadow_store[OFS_DDIST]};
    if (!eng) begin
      r.last = 1'b1;
      recs.push_back(r);
      return;
    end
    r.light_level = shadow_store[OFS_LIGHT];
    r.out_pin     = (shadow_store[OFS_PIN] != 8'h00);
    recs.push_back(r);
    r              = '0;
    r.kind         = KIND_LIMITS;
    r.moving_value = shadow_store[OFS_MAX_MOVE];
    r.still_value  = shadow_store[OFS_MAX_STILL];
    recs.push_back(r);
    for (int g = 0; g < GATE_COUNT; g++) begin
      r              = '0;
      r.kind         = KIND_GATE;
      r.gate_index   = 4'(g);
      r.moving_value = shadow_store[OFS_MOVE_GATE + g];
      r.still_value  = shadow_store[OFS_STILL_GATE + g];
      r.last         = (g == GATE_COUNT - 1);
      recs.push_back(r);
    end
  endtask

  // Drop the current frame with an error report.
  task automatic drop_frame(ref result_t recs[$]);
    shadow_in_frame = 1'b0;
    shadow_fill     = 0;
    recs.push_back(error_record());
  endtask

  // Advance the shadow parser by one byte and collect the reports it causes.
  task automatic parse_byte(input logic [7:0] b, ref result_t recs[$]);
    int unsigned p;
    logic [15:0] len_word;
    logic [31:0] tail;
    recs.delete();
    if (!shadow_enable) return;
    if (!shadow_in_frame) begin
      if (b == START_DATA || b == START_ACK) begin
        shadow_store[0] = b;
        shadow_fill     = 1;
        shadow_in_frame = 1'b1;
        shadow_ack      = (b == START_ACK);
      end
      return;
    end
    if (shadow_fill >= MAX_FRAME_BYTES) begin
      drop_frame(recs);
      return;
    end
    shadow_store[shadow_fill] = b;
    shadow_fill++;
    p = shadow_fill;
    if (p == 8) begin
      len_word = {shadow_store[OFS_LEN_HI], shadow_store[OFS_LEN_LO]};
      if (int'(len_word) + LEN_OVERHEAD > MAX_FRAME_BYTES) begin
        drop_frame(recs);
        return;
      end
    end
    if (p >= 8) begin
      tail = {shadow_store[p-4], shadow_store[p-3], shadow_store[p-2], shadow_store[p-1]};
      if (shadow_ack && tail == {FOOT_A0, FOOT_A1, FOOT_A2, FOOT_A3}) begin
        shadow_in_frame = 1'b0;
        return;
      end
      if (!shadow_ack && tail == {FOOT_D0, FOOT_D1, FOOT_D2, FOOT_D3}) begin
        shadow_in_frame = 1'b0;
        decode_frame(recs);
        return;
      end
    end
    if (p >= MAX_FRAME_BYTES) drop_frame(recs);
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("report %0d field %s: got %0h, expected %0h",
                                report_count, name, got, want));
  endtask

  // Compare one accepted report with the oldest expectation.
  task automatic check_report(input result_t got);
    result_t want;
    if (expected_reports.size() == 0) begin
      report_mismatch($sformatf("report %0d arrived with nothing expected (kind %0d)",
                                report_count, got.kind));
      return;
    end
    want = expected_reports.pop_front();
    compare_field("kind", 16'(got.kind), 16'(want.kind));
    compare_field("target_state", 16'(got.target_state), 16'(want.target_state));
    compare_field("moving_distance", got.moving_distance, want.moving_distance);
    compare_field("moving_value", 16'(got.moving_value), 16'(want.moving_value));
    compare_field("still_distance", got.still_distance, want.still_distance);
    compare_field("still_value", 16'(got.still_value), 16'(want.still_value));
    compare_field("detect_distance", got.detect_distance, want.detect_distance);
    compare_field("gate_index", 16'(got.gate_index), 16'(want.gate_index));
    compare_field("light_level", 16'(got.light_level), 16'(want.light_level));
    compare_field("out_pin", 16'(got.out_pin), 16'(want.out_pin));
    compare_field("last", 16'(got.last), 16'(want.last));
  endtask

  // Monitor: reports are checked before the byte request of the same edge is predicted.
  always @(posedge clk) begin
    if (!rst) begin
      if (rep_ch.valid && rep_ch.ready) begin
        check_report(rep_ch.payload);
        report_count++;
      end
      if (rx_ch.valid && rx_ch.ready) begin
        parse_byte(rx_ch.rx_byte, step_reports);
        predicted_total += step_reports.size();
        if (!tag_typed) begin
          foreach (step_reports[i]) expected_reports.push_back(step_reports[i]);
        end else if (tag_end && rows[tag_row].n_exp > 0) begin
          expected_reports.push_back(rows[tag_row].exp_rec);
        end
      end
    end
  end

  // Report sink: random stall bursts, none in the calm tail.
  always @(posedge clk) begin
    int stall;
    if (rst || calm) begin
      rep_ch.ready <= 1'b1;
    end else if (stall > 0) begin
      stall--;
      rep_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < sink_idle_pct) begin
      stall = $urandom_range(1, 16) - 1;
      rep_ch.ready <= 1'b0;
    end else begin
      rep_ch.ready <= 1'b1;
    end
  end

  // Send one byte request, after an optional idle burst.
  task automatic send_byte(input logic [7:0] b, input logic typed, input logic row_end,
                           input int row);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < src_idle_pct) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    tag_typed     <= typed;
    tag_end       <= row_end;
    tag_row       <= row;
    do @(posedge clk); while (!rx_ch.ready);
  endtask

  // Wait until every expected report has come and the block has gone quiet.
  task automatic settle();
    rx_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(input logic v);
    settle();
    cfg_ch.valid     <= 1'b1;
    cfg_ch.rx_enable <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid  <= 1'b0;
    shadow_enable = v;
  endtask

  // Append the scratch bytes as a row of the directed table.
  task automatic add_row(input row_op_t op, input logic typed, input int n_exp,
                         input result_t exp_rec);
    stim_row_t r;
    r.op      = op;
    r.count   = scratch.size();
    r.bytes   = '0;
    r.typed   = typed;
    r.n_exp   = n_exp;
    r.exp_rec = exp_rec;
    foreach (scratch[k]) r.bytes[k] = scratch[k];
    rows.push_back(r);
  endtask

  initial begin
    result_t     rec;
    int          pick;
    int          n;
    int          rand_bytes;
    int          report_base;
    logic        footer_on;
    logic        en;
    logic [7:0]  typ;
    logic [7:0]  head;
    logic [15:0] len_word;

    clk              = 1'b0;
    rst              = 1'b1;
    rx_ch.valid      = 1'b0;
    rx_ch.rx_byte    = 8'h00;
    cfg_ch.valid     = 1'b0;
    cfg_ch.rx_enable = 1'b0;
    rep_ch.ready     = 1'b0;
    tag_typed        = 1'b0;
    tag_end          = 1'b0;
    tag_row          = 0;
    mismatches       = 0;
    report_count     = 0;
    predicted_total  = 0;
    cycle_count      = 0;
    src_idle_pct     = 20;
    sink_idle_pct    = 20;
    calm             = 1'b0;
    shadow_enable    = 1'b0;
    shadow_in_frame  = 1'b0;
    shadow_ack       = 1'b0;
    shadow_fill      = 0;
    foreach (shadow_store[i]) shadow_store[i] = 8'h00;

    // Directed table.
    // A full basic frame while disabled is ignored.
    scratch = '{8'hF4, 8'hF3, 8'hF2, 8'hF1, 8'h0D, 8'h00, TYPE_BASIC, HEAD_BYTE,
                8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                8'h55, 8'h00, FOOT_D0, FOOT_D1, FOOT_D2, FOOT_D3};
    add_row(ROW_BYTES, 1'b1, 0, '0);
    scratch = '{8'h01};
    add_row(ROW_ENABLE, 1'b0, 0, '0);
    // The same frame with every summary field at its maximum.
    rec                 = '0;
    rec.kind            = KIND_BASIC;
    rec.target_state    = 8'hFF;
    rec.moving_distance = 16'hFFFF;
    rec.moving_value    = 8'hFF;
    rec.still_distance  = 16'hFFFF;
    rec.still_value     = 8'hFF;
    rec.detect_distance = 16'hFFFF;
    rec.last            = 1'b1;
    scratch = '{8'hF4, 8'hF3, 8'hF2, 8'hF1, 8'h0D, 8'h00, TYPE_BASIC, HEAD_BYTE,
                8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                8'h55, 8'h00, FOOT_D0, FOOT_D1, FOOT_D2, FOOT_D3};
    add_row(ROW_BYTES, 1'b1, 1, rec);
    // Zero and mixed summary fields, checking byte order.
    rec                 = '0;
    rec.kind            = KIND_BASIC;
    rec.moving_distance = 16'h1234;
    rec.still_distance  = 16'h5678;
    rec.still_value     = 8'h01;
    rec.detect_distance = 16'hABCD;
    rec.last            = 1'b1;
    scratch = '{8'hF4, 8'hF3, 8'hF2, 8'hF1, 8'h0D, 8'h00, TYPE_BASIC, HEAD_BYTE,
                8'h00, 8'h34, 8'h12, 8'h00, 8'h78, 8'h56, 8'h01, 8'hCD, 8'hAB,
                8'h55, 8'h00, FOOT_D0, FOOT_D1, FOOT_D2, FOOT_D3};
    add_row(ROW_BYTES, 1'b1, 1, rec);
    // A short engineering frame reads stale store bytes past its end.
    scratch = '{8'hF4, 8'hF3, 8'hF2, 8'hF1, 8'h0D, 8'h00, TYPE_ENG, HEAD_BYTE,
                8'h03, 8'h10, 8'h00, 8'h40, 8'h20, 8'h00, 8'h50, 8'h30, 8'h00,
                8'h08, 8'h07, FOOT_D0, FOOT_D1, FOOT_D2, FOOT_D3};
    add_row(ROW_BYTES, 1'b0, 0, '0);
    // A full engineering frame with light at its maximum and the pin set.
    scratch = '{8'hF4, 8'hF3, 8'hF2, 8'hF1, 8'h23, 8'h00, TYPE_ENG, HEAD_BYTE};
    for (int i = OFS_STATE; i < OFS_LIGHT; i++) scratch.push_back(8'(i * 9));
    scratch.push_back(8'hFF);
    scratch.push_back(8'h01);
    scratch.push_back(8'h55);
    scratch.push_back(8'h00);
    scratch.push_back(FOOT_D0);
    scratch.push_back(FOOT_D1);
    scratch.push_back(FOOT_D2);
    scratch.push_back(FOOT_D3);
    add_row(ROW_BYTES, 1'b0, 0, '0);
    // An acknowledgement frame holding a data footer emits nothing.
    scratch = '{START_ACK, 8'hFC, 8'hFB, 8'hFA, 8'h08, 8'h00, 8'hFF, 8'h00,
                FOOT_D0, FOOT_D1, FOOT_D2, FOOT_D3, FOOT_A0, FOOT_A1, FOOT_A2, FOOT_A3};
    add_row(ROW_BYTES, 1'b1, 0, '0);
    // Length word one past the limit.
    scratch = '{8'hF4, 8'hF3, 8'hF2, 8'hF1, 8'h37, 8'h00, TYPE_ENG, HEAD_BYTE};
    add_row(ROW_BYTES, 1'b1, 1, error_record());
    // Largest length word.
    scratch = '{8'hF4, 8'hF3, 8'hF2, 8'hF1, 8'hFF, 8'hFF, TYPE_BASIC, HEAD_BYTE};
    add_row(ROW_BYTES, 1'b1, 1, error_record());
    // Length word at the limit, then the store fills without a footer.
    scratch = '{8'hF4, 8'hF3, 8'hF2, 8'hF1, 8'h36, 8'h00, TYPE_BASIC, HEAD_BYTE};
    repeat (MAX_FRAME_BYTES - 8) scratch.push_back(8'h00);
    add_row(ROW_BYTES, 1'b1, 1, error_record());
    // Footer ending in the last store position.
    scratch = '{8'hF4, 8'hF3, 8'hF2, 8'hF1, 8'h36, 8'h00, TYPE_BASIC, HEAD_BYTE};
    for (int i = 8; i < MAX_FRAME_BYTES - 4; i++) scratch.push_back(8'(i));
    scratch.push_back(FOOT_D0);
    scratch.push_back(FOOT_D1);
    scratch.push_back(FOOT_D2);
    scratch.push_back(FOOT_D3);
    add_row(ROW_BYTES, 1'b0, 0, '0);
    // Unknown type byte.
    scratch = '{8'hF4, 8'hF3, 8'hF2, 8'hF1, 8'h0D, 8'h00, 8'h03, HEAD_BYTE,
                8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88, 8'h99,
                8'h55, 8'h00, FOOT_D0, FOOT_D1, FOOT_D2, FOOT_D3};
    add_row(ROW_BYTES, 1'b1, 0, '0);
    // Wrong head byte.
    scratch = '{8'hF4, 8'hF3, 8'hF2, 8'hF1, 8'h0D, 8'h00, TYPE_BASIC, 8'hAB,
                8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88, 8'h99,
                8'h55, 8'h00, FOOT_D0, FOOT_D1, FOOT_D2, FOOT_D3};
    add_row(ROW_BYTES, 1'b1, 0, '0);
    // Noise while hunting, then a data frame holding an acknowledgement footer.
    scratch = '{8'h00, 8'hFF, FOOT_D3, 8'h01, 8'hF4, 8'hF3, 8'hF2, 8'hF1, 8'h0D, 8'h00,
                TYPE_BASIC, HEAD_BYTE, FOOT_A0, FOOT_A1, FOOT_A2, FOOT_A3, 8'h5A, 8'hA5,
                8'h80, 8'h7F, 8'h01, 8'h55, 8'h00, FOOT_D0, FOOT_D1, FOOT_D2, FOOT_D3};
    add_row(ROW_BYTES, 1'b0, 0, '0);
    // An engineering frame split by a disabled stretch, which keeps the state.
    scratch = '{8'hF4, 8'hF3, 8'hF2, 8'hF1, 8'h23, 8'h00, TYPE_ENG, HEAD_BYTE,
                8'h11, 8'h22};
    add_row(ROW_BYTES, 1'b0, 0, '0);
    scratch = '{8'h00};
    add_row(ROW_ENABLE, 1'b0, 0, '0);
    scratch = '{FOOT_D0, FOOT_D1, FOOT_D2, FOOT_D3, 8'hF4};
    add_row(ROW_BYTES, 1'b1, 0, '0);
    scratch = '{8'h01};
    add_row(ROW_ENABLE, 1'b0, 0, '0);
    scratch.delete();
    for (int i = OFS_MDIST + 1; i < OFS_PIN; i++) scratch.push_back(8'(255 - i * 5));
    scratch.push_back(8'h00);
    scratch.push_back(8'h55);
    scratch.push_back(8'h00);
    scratch.push_back(FOOT_D0);
    scratch.push_back(FOOT_D1);
    scratch.push_back(FOOT_D2);
    scratch.push_back(FOOT_D3);
    add_row(ROW_BYTES, 1'b0, 0, '0);

    // Reset.
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table.
    foreach (rows[i]) begin
      if (rows[i].op == ROW_ENABLE) begin
        write_enable(rows[i].bytes[0][0]);
      end else begin
        for (int k = 0; k < rows[i].count; k++)
          send_byte(rows[i].bytes[k], rows[i].typed, k == rows[i].count - 1, i);
      end
    end

    // Random phases: mostly well-formed frames with random content.
    rand_bytes  = 0;
    report_base = predicted_total;
    while (rand_bytes < RANDOM_BYTES || predicted_total - report_base < MIN_REPORTS) begin
      en = ($urandom_range(0, 4) != 0);
      write_enable(en);
      case ($urandom_range(0, 2))
        0: src_idle_pct = 0;
        1: src_idle_pct = 15;
        default: src_idle_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0: sink_idle_pct = 0;
        1: sink_idle_pct = 15;
        default: sink_idle_pct = 40;
      endcase
      repeat (en ? $urandom_range(2, 5) : 1) begin
        calm = (rand_bytes >= CALM_BYTES);
        pick = $urandom_range(0, 9);
        scratch.delete();
        if (pick == 9) begin
          // Loose bytes, which may open a frame by chance.
          n = $urandom_range(1, 12);
          repeat (n) scratch.push_back(8'($urandom));
        end else begin
          footer_on = 1'b1;
          len_word  = 16'($urandom_range(0, MAX_LEN_OK));
          typ       = TYPE_BASIC;
          head      = HEAD_BYTE;
          case (pick)
            0, 1, 2, 3: begin
              typ = TYPE_ENG;
              n   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30)
                                                : $urandom_range(31, MAX_BODY);
            end
            6: begin
              typ = 8'($urandom);
              head = 8'($urandom);
              n   = $urandom_range(0, 20);
            end
            7: begin
              typ = 8'($urandom);
              if ($urandom_range(0, 1) == 0) head = 8'($urandom);
              n = $urandom_range(9, 20);
            end
            8: begin
              len_word = 16'($urandom_range(MAX_LEN_OK + 1, 65535));
              n        = $urandom_range(0, 6);
            end
            default: begin
              n = $urandom_range(9, 24);
              if ($urandom_range(0, 7) == 0) begin
                // Overrun: the store fills without a footer.
                n         = MAX_FRAME_BYTES - 8;
                footer_on = 1'b0;
              end
            end
          endcase
          scratch.push_back((pick == 6) ? START_ACK : START_DATA);
          repeat (3) scratch.push_back(8'($urandom));
          scratch.push_back(len_word[7:0]);
          scratch.push_back(len_word[15:8]);
          scratch.push_back(typ);
          scratch.push_back(head);
          repeat (n) scratch.push_back(8'($urandom));
          if (footer_on && pick == 6) begin
            scratch.push_back(FOOT_A0);
            scratch.push_back(FOOT_A1);
            scratch.push_back(FOOT_A2);
            scratch.push_back(FOOT_A3);
          end else if (footer_on) begin
            scratch.push_back(FOOT_D0);
            scratch.push_back(FOOT_D1);
            scratch.push_back(FOOT_D2);
            scratch.push_back(FOOT_D3);
          end
        end
        foreach (scratch[k]) begin
          send_byte(scratch[k], 1'b0, 1'b0, 0);
          if (shadow_enable) rand_bytes++;
        end
      end
    end

    // Drain and finish.
    calm = 1'b1;
    settle();
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
